@@ hw/rtl/sebp_pkg.sv @@
// Shared types and constants for the STX/ETX block-check frame parser.
// No dependencies; imported by sebp_deframer and stx_etx_bcc_frame_parser.
package sebp_pkg;

  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] EndByte   = 8'h03;

  localparam int unsigned LenW = 16;

  typedef enum logic [2:0] {
    EvType    = 3'd0,
    EvInstr   = 3'd1,
    EvPayload = 3'd2,
    EvGood    = 3'd3,
    EvDrop    = 3'd4
  } event_e;

  // Input operation codes.
  localparam logic OpByte    = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef struct packed {
    logic            valid;
    event_e          ev;
    logic [7:0]      value;
    logic [LenW-1:0] index;
    logic [LenW-1:0] length;
    logic            last;
  } result_t;

endpackage

@@ hw/rtl/sebp_deframer.sv @@
// Frame state machine with length, payload counter and running XOR check.
// Depends on sebp_pkg. Produces at most one result per processed request.
module sebp_deframer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             operation_i,
  input  logic [7:0]       rx_byte_i,
  output sebp_pkg::result_t res_o
);
  import sebp_pkg::*;

  typedef enum logic [8:0] {
    StHunt    = 9'b000000001,
    StLenHi   = 9'b000000010,
    StLenLo   = 9'b000000100,
    StType    = 9'b000001000,
    StInstr   = 9'b000010000,
    StPayload = 9'b000100000,
    StTail    = 9'b001000000,
    StCheck   = 9'b010000000,
    StDone    = 9'b100000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] count_q, count_d;
  logic [7:0]      check_q, check_d;
  logic [LenW-1:0] len_lo;
  logic [LenW:0]   count_inc;
  logic [LenW:0]   payload_len;
  logic            is_last;

  assign len_lo      = {len_q[LenW-1:8], rx_byte_i};
  assign count_inc   = {1'b0, count_q} + 17'd1;
  assign payload_len = {1'b0, len_q} - 17'd2;
  assign is_last     = (count_inc >= payload_len);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    count_d = count_q;
    check_d = check_q;
    res_o   = '{valid: 1'b0, ev: EvType, value: rx_byte_i, index: '0,
                length: len_q, last: 1'b0};
    if (operation_i == OpRelease) begin
      phase_d = StHunt;
      len_d   = '0;
      count_d = '0;
      check_d = '0;
    end else begin
      unique case (phase_q)
        StLenHi: begin
          len_d   = {rx_byte_i, 8'h00};
          check_d = check_q ^ rx_byte_i;
          phase_d = StLenLo;
        end
        StLenLo: begin
          if (len_lo < 16'd2) begin
            // Short length: drop, reporting the full received length.
            res_o.valid  = 1'b1;
            res_o.ev     = EvDrop;
            res_o.length = len_lo;
            phase_d = StHunt;
            len_d   = '0;
            count_d = '0;
            check_d = '0;
          end else begin
            len_d   = len_lo;
            check_d = check_q ^ rx_byte_i;
            phase_d = StType;
          end
        end
        StType: begin
          res_o.valid = 1'b1;
          res_o.ev    = EvType;
          check_d = check_q ^ rx_byte_i;
          phase_d = StInstr;
        end
        StInstr: begin
          res_o.valid = 1'b1;
          res_o.ev    = EvInstr;
          check_d = check_q ^ rx_byte_i;
          count_d = '0;
          phase_d = (len_q == 16'd2) ? StTail : StPayload;
        end
        StPayload: begin
          res_o.valid = 1'b1;
          res_o.ev    = EvPayload;
          res_o.index = count_q;
          res_o.last  = is_last;
          check_d = check_q ^ rx_byte_i;
          count_d = count_inc[LenW-1:0];
          if (is_last) phase_d = StTail;
        end
        StTail: begin
          if (rx_byte_i != EndByte) begin
            res_o.valid = 1'b1;
            res_o.ev    = EvDrop;
            phase_d = StHunt;
            len_d   = '0;
            count_d = '0;
            check_d = '0;
          end else begin
            check_d = check_q ^ EndByte;
            phase_d = StCheck;
          end
        end
        StCheck: begin
          res_o.valid = 1'b1;
          if (rx_byte_i != check_q) begin
            res_o.ev = EvDrop;
            phase_d = StHunt;
            len_d   = '0;
            count_d = '0;
            check_d = '0;
          end else begin
            res_o.ev = EvGood;
            phase_d  = StDone;
          end
        end
        StDone: begin
          phase_d = StDone;
        end
        default: begin
          // Hunting, or an unexpected phase code, which behaves the same.
          len_d   = '0;
          count_d = '0;
          if (rx_byte_i == StartByte) begin
            check_d = StartByte;
            phase_d = StLenHi;
          end else begin
            check_d = '0;
            phase_d = StHunt;
          end
        end
      endcase
    end
    if (!fire_i) res_o.valid = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= StHunt;
      len_q   <= '0;
      count_q <= '0;
      check_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
      check_q <= check_d;
    end
  end

endmodule

@@ hw/rtl/stx_etx_bcc_frame_parser.sv @@
// Top level of the STX/ETX frame parser with XOR block check.
// Depends on sebp_pkg and sebp_deframer.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   operation_i, rx_byte_i
//   output    out        out_valid_o / out_stall_i event_res_o, value_o,
//                                                  payload_index_o,
//                                                  frame_length_o, last_payload_o
//
// Each request passes through the input register, and its result, if any, is then
// held in the result register, which drives the outputs. One request per cycle is
// sustained while the output does not stall.
// Reset (rst_ni low, asynchronous) empties both registers and puts the frame
// state machine back to hunting for a start byte. A stall on the output holds
// the result register and, once the input register is also full, stalls the input.
module stx_etx_bcc_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  value_o,
  output logic [15:0] payload_index_o,
  output logic [15:0] frame_length_o,
  output logic        last_payload_o
);
  import sebp_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] byte_q;

  // Result register.
  logic    out_valid_q;
  result_t out_q;

  result_t res;
  logic    out_free;
  logic    advance;

  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held request is processed whenever its result has somewhere to go.
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  sebp_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .operation_i (op_q),
    .rx_byte_i   (byte_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_q.ev;
  assign value_o         = out_q.value;
  assign payload_index_o = out_q.index;
  assign frame_length_o  = out_q.length;
  assign last_payload_o  = out_q.last;

endmodule
